### hw/rtl/sfb_pkg.sv
`timescale 1ns / 1ps

package sfb_pkg;

    // Checksum and stuffing constants
    localparam logic [15:0] SUM_SEED   = 16'h147A;
    localparam logic [7:0]  STUFF_MARK = 8'hFE;
    localparam logic [7:0]  STUFF_FILL = 8'hF0;

    // Register reset values
    localparam logic [7:0]  HDR_RESET  = 8'hFE;
    localparam logic [7:0]  END_RESET  = 8'h0D;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd1;

    // Command queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    // One classified payload byte, ready for the back end
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        hdr;
        logic [15:0] sum;
    } t_cmd;

endpackage

### hw/rtl/sfb_front.sv
`timescale 1ns / 1ps

module sfb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    input  logic          i_q_full,
    output logic          o_push,
    output sfb_pkg::t_cmd o_cmd
);

    logic [15:0] r_sum;
    logic [15:0] n_sum;
    logic        r_inside;
    logic        n_inside;
    logic [15:0] w_rot;
    logic [15:0] w_upd;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;

    // Rotate left, invert, then add own high byte and the data byte
    always_comb begin
        w_rot = ~{r_sum[14:0], r_sum[15]};
        w_upd = w_rot + {8'h00, w_rot[15:8]} + {8'h00, i_data_byte};
    end

    // Classify the transaction for the back end
    always_comb begin
        o_cmd.data = i_data_byte;
        o_cmd.last = i_last_byte;
        o_cmd.hdr  = !r_inside;
        o_cmd.sum  = w_upd;
    end

    // Frame state update
    always_comb begin
        n_sum    = r_sum;
        n_inside = r_inside;
        if (o_push) begin
            n_sum    = i_last_byte ? sfb_pkg::SUM_SEED : w_upd;
            n_inside = !i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= sfb_pkg::SUM_SEED;
            r_inside <= 1'b0;
        end else begin
            r_sum    <= n_sum;
            r_inside <= n_inside;
        end
    end

endmodule

### hw/rtl/sfb_queue.sv
`timescale 1ns / 1ps

module sfb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfb_pkg::t_cmd i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sfb_pkg::t_cmd o_head
);

    sfb_pkg::t_cmd                r_mem [sfb_pkg::QDEPTH];
    logic [sfb_pkg::QAW-1:0]      r_wr_ptr;
    logic [sfb_pkg::QAW-1:0]      r_rd_ptr;
    logic [sfb_pkg::QAW:0]        r_count;
    logic [sfb_pkg::QAW:0]        n_count;

    assign o_full  = (r_count == (sfb_pkg::QAW+1)'(sfb_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

### hw/rtl/sfb_back.sv
`timescale 1ns / 1ps

module sfb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_header_byte,
    input  logic [7:0]    i_end_byte,
    input  logic          i_q_empty,
    input  sfb_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_run_end,
    output logic          o_frame_end
);

    // Sequencer steps
    localparam logic [3:0] S_HDR1  = 4'd0;
    localparam logic [3:0] S_HDR2  = 4'd1;
    localparam logic [3:0] S_DATA  = 4'd2;
    localparam logic [3:0] S_DSTF  = 4'd3;
    localparam logic [3:0] S_CHI   = 4'd4;
    localparam logic [3:0] S_CHSTF = 4'd5;
    localparam logic [3:0] S_CLO   = 4'd6;
    localparam logic [3:0] S_CLSTF = 4'd7;
    localparam logic [3:0] S_TRHDR = 4'd8;
    localparam logic [3:0] S_END   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] r_step;
    logic       r_active;
    logic [3:0] w_cur;
    logic [3:0] w_next;
    logic [7:0] w_byte;
    logic       w_fend;
    logic       w_emit;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_end;
    logic       r_fend;

    assign w_cur  = r_active ? r_step : (i_head.hdr ? S_HDR1 : S_DATA);
    assign w_emit = !i_q_empty && (!r_valid || i_ready);
    assign o_pop  = w_emit && (w_next == S_DONE);

    // Next step and emitted byte
    always_comb begin
        w_next = S_DONE;
        w_byte = i_header_byte;
        w_fend = 1'b0;
        unique case (w_cur)
            S_HDR1: begin
                w_next = S_HDR2;
            end
            S_HDR2: begin
                w_next = S_DATA;
            end
            S_DATA: begin
                w_byte = i_head.data;
                if (i_head.data == sfb_pkg::STUFF_MARK) begin
                    w_next = S_DSTF;
                end else begin
                    w_next = i_head.last ? S_CHI : S_DONE;
                end
            end
            S_DSTF: begin
                w_byte = sfb_pkg::STUFF_FILL;
                w_next = i_head.last ? S_CHI : S_DONE;
            end
            S_CHI: begin
                w_byte = i_head.sum[15:8];
                w_next = (i_head.sum[15:8] == sfb_pkg::STUFF_MARK) ? S_CHSTF : S_CLO;
            end
            S_CHSTF: begin
                w_byte = sfb_pkg::STUFF_FILL;
                w_next = S_CLO;
            end
            S_CLO: begin
                w_byte = i_head.sum[7:0];
                w_next = (i_head.sum[7:0] == sfb_pkg::STUFF_MARK) ? S_CLSTF : S_TRHDR;
            end
            S_CLSTF: begin
                w_byte = sfb_pkg::STUFF_FILL;
                w_next = S_TRHDR;
            end
            S_TRHDR: begin
                w_next = S_END;
            end
            S_END: begin
                w_byte = i_end_byte;
                w_fend = 1'b1;
                w_next = S_DONE;
            end
            default: begin
                w_next = S_DONE;
            end
        endcase
    end

    // Step pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_step   <= S_HDR1;
        end else if (w_emit) begin
            r_active <= (w_next != S_DONE);
            r_step   <= w_next;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_byte    <= w_byte;
            r_run_end <= (w_next == S_DONE);
            r_fend    <= w_fend;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_run_end   = r_run_end;
    assign o_frame_end = r_fend;

    // Checks
    a_fend_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> o_run_end)
        else $error("frame end byte not last of its transaction");

    a_end_after_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_cur == S_END) |-> (r_active && i_head.last))
        else $error("end byte outside a closing transaction");

endmodule

### hw/rtl/stuffed_frame_builder_with_checksum.sv
`timescale 1ns / 1ps

// Byte-stuffed framer with a rotating 16-bit checksum.
// Input channel (i_valid/o_ready) takes one payload byte per transaction,
// i_last_byte marking the final byte of a frame. The first byte of a frame
// is preceded by two header bytes; payload and checksum bytes equal to 0xFE
// are followed by 0xF0; the last byte is followed by the checksum (high,
// low), one header byte and the end byte (o_frame_end set).
// Output channel (o_valid/i_ready) carries one line byte per transaction;
// o_run_end marks the last byte caused by an input transaction.
// Config channel (i_cfg_valid/o_cfg_ready, always ready) writes index 0
// (header byte) or 1 (end byte); other indexes are ignored.
// With the back end idle, an accepted byte is written into the command queue
// and its first output byte is then loaded into the output register.
// The output sequencer sends one byte per cycle while the receiver is ready,
// and an input transaction yields 1 to 10 line bytes; a four-entry command queue
// lets input continue while it drains. When the receiver stalls the queue
// fills and o_ready drops. Reset empties the queue and the output register,
// reseeds the checksum to 0x147A, closes any open frame and restores the
// register defaults (0xFE, 0x0D).

module stuffed_frame_builder_with_checksum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_out_byte,
    output logic                          o_run_end,
    output logic                          o_frame_end,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);

    logic [7:0]    r_header_byte;
    logic [7:0]    r_end_byte;
    logic          w_q_full;
    logic          w_q_empty;
    logic          w_push;
    logic          w_pop;
    sfb_pkg::t_cmd w_cmd;
    sfb_pkg::t_cmd w_head;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte <= sfb_pkg::HDR_RESET;
            r_end_byte    <= sfb_pkg::END_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == sfb_pkg::CFG_HEADER) begin
                r_header_byte <= i_cfg_data;
            end else if (i_cfg_index == sfb_pkg::CFG_END) begin
                r_end_byte <= i_cfg_data;
            end
        end
    end

    sfb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    sfb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_cmd),
        .o_full      (w_q_full),
        .i_pop       (w_pop),
        .o_empty     (w_q_empty),
        .o_head      (w_head)
    );

    sfb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_header_byte (r_header_byte),
        .i_end_byte    (r_end_byte),
        .i_q_empty     (w_q_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_run_end     (o_run_end),
        .o_frame_end   (o_frame_end)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Spare register indexes: writes there must leave the block unchanged
    localparam logic [sfb_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [sfb_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS = 15;

    typedef struct packed {
        logic [7:0] val;
        logic       run_end;
        logic       frame_end;
    } t_line_byte;

    // Directed row: payload, last flag, count of typed-in line bytes (0: use predictor)
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [2:0]  n_typed;
        logic [31:0] typed;
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic [7:0]                    i_data_byte = 8'h00;
    logic                          i_last_byte = 1'b0;
    logic                          i_ready = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic [sfb_pkg::CFG_IDX_W-1:0] i_cfg_index = sfb_pkg::CFG_HEADER;
    logic [7:0]                    i_cfg_data = 8'h00;
    logic                          o_ready;
    logic                          o_valid;
    logic [7:0]                    o_out_byte;
    logic                          o_run_end;
    logic                          o_frame_end;
    logic                          o_cfg_ready;

    // Predictor state and register shadows
    logic [15:0] run_sum = sfb_pkg::SUM_SEED;
    logic        frame_open = 1'b0;
    logic [7:0]  hdr_cfg = sfb_pkg::HDR_RESET;
    logic [7:0]  end_cfg = sfb_pkg::END_RESET;

    t_line_byte  line_exp_q[$];
    t_line_byte  want;
    t_dir_row    dir_tab [0:DIR_ROWS-1];
    logic [7:0]  hdr_plan [1:7];
    logic [7:0]  end_plan [1:7];
    logic        calm = 1'b0;
    int          mismatches = 0;
    int unsigned cycle_cnt = 0;

    stuffed_frame_builder_with_checksum u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_run_end   (o_run_end),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Rotate left, invert, add own high byte and the data byte
    function automatic logic [15:0] chk_next(input logic [15:0] s, input logic [7:0] b);
        logic [15:0] r;
        r = {s[14:0], s[15]} ^ 16'hFFFF;
        r = r + {8'h00, r[15:8]} + {8'h00, b};
        return r;
    endfunction

    // Line bytes caused by one payload byte; state always advances
    function automatic void frame_model(input logic [7:0] b, input logic last,
                                        input bit record);
        logic [7:0] vals [0:9];
        logic       ends [0:9];
        logic [7:0] pay [0:2];
        int         n;
        int         np;
        int         k;
        t_line_byte e;
        n = 0;
        if (!frame_open) begin
            vals[0] = hdr_cfg; ends[0] = 1'b0;
            vals[1] = hdr_cfg; ends[1] = 1'b0;
            n = 2;
            frame_open = 1'b1;
        end
        run_sum = chk_next(run_sum, b);
        pay[0] = b;
        np = 1;
        if (last) begin
            pay[1] = run_sum[15:8];
            pay[2] = run_sum[7:0];
            np = 3;
        end
        // payload and checksum bytes are stuffed, header and end never
        for (k = 0; k < np; k++) begin
            vals[n] = pay[k]; ends[n] = 1'b0; n++;
            if (pay[k] == sfb_pkg::STUFF_MARK) begin
                vals[n] = sfb_pkg::STUFF_FILL; ends[n] = 1'b0; n++;
            end
        end
        if (last) begin
            vals[n] = hdr_cfg; ends[n] = 1'b0; n++;
            vals[n] = end_cfg; ends[n] = 1'b1; n++;
            run_sum = sfb_pkg::SUM_SEED;
            frame_open = 1'b0;
        end
        if (record) begin
            for (k = 0; k < n; k++) begin
                e.val = vals[k];
                e.run_end = (k == n - 1);
                e.frame_end = ends[k];
                line_exp_q.insert(line_exp_q.size(), e);
            end
        end
    endfunction

    // Closing byte that makes a checksum byte hit the stuffing mark, if one exists
    function automatic logic [7:0] pick_tail(input bit hi);
        int          i;
        logic [15:0] nx;
        for (i = 0; i < 256; i++) begin
            nx = chk_next(run_sum, i[7:0]);
            if ((hi && nx[15:8] == sfb_pkg::STUFF_MARK) ||
                (!hi && nx[7:0] == sfb_pkg::STUFF_MARK))
                return i[7:0];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Payload biased toward the stuffing mark, the fill value and the extremes
    function automatic logic [7:0] rand_payload();
        unique case ($urandom_range(0, 9))
            0, 1:    return sfb_pkg::STUFF_MARK;
            2:       return 8'h00;
            3:       return 8'hFF;
            4:       return sfb_pkg::STUFF_FILL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic write_reg(input logic [sfb_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] v);
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        unique case (idx)
            sfb_pkg::CFG_HEADER: hdr_cfg = v;
            sfb_pkg::CFG_END:    end_cfg = v;
            default:             ;
        endcase
        @(posedge i_clk);
    endtask

    // Random sender gap; with drain, hold until every line byte has come
    task automatic hold_off(input bit drain);
        int g;
        g = 0;
        while (!calm && $urandom_range(0, 99) < 24)
            g++;
        if (drain && g == 0)
            g = 1;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
            if (drain) begin
                while (line_exp_q.size() != 0)
                    @(posedge i_clk);
            end
        end
    endtask

    task automatic send_payload(input logic [7:0] b, input logic last,
                                input logic [2:0] n_typed, input logic [31:0] typed);
        int         k;
        t_line_byte e;
        i_data_byte <= b;
        i_last_byte <= last;
        i_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        frame_model(b, last, n_typed == 3'd0);
        for (k = 0; k < n_typed; k++) begin
            e.val = typed[31 - 8 * k -: 8];
            e.run_end = (k == n_typed - 1);
            e.frame_end = 1'b0;
            line_exp_q.insert(line_exp_q.size(), e);
        end
    endtask

    // Receiver stalls
    always @(posedge i_clk) begin
        if (calm)
            i_ready <= 1'b1;
        else
            i_ready <= ($urandom_range(0, 99) >= 24);
    end

    // Check each output transaction against the oldest expected line byte
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (line_exp_q.size() == 0) begin
                $display("%0t: line byte %02h with none expected", $time, o_out_byte);
                mismatches++;
            end else begin
                want = line_exp_q.pop_front();
                if (o_out_byte !== want.val) begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.val, o_out_byte);
                    mismatches++;
                end
                if (o_run_end !== want.run_end) begin
                    $display("%0t: run_end expected %0b actual %0b",
                             $time, want.run_end, o_run_end);
                    mismatches++;
                end
                if (o_frame_end !== want.frame_end) begin
                    $display("%0t: frame_end expected %0b actual %0b",
                             $time, want.frame_end, o_frame_end);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        int         ph;
        int         k;
        int         len;
        int         left;
        logic [7:0] d;
        logic       lst;

        // Directed rows; typed-in values assume the reset header byte
        dir_tab[0]  = '{8'hFE, 1'b0, 3'd4, 32'hFEFEFEF0};  // opens frame, stuffed
        dir_tab[1]  = '{8'h00, 1'b0, 3'd1, 32'h00000000};
        dir_tab[2]  = '{8'hFF, 1'b0, 3'd1, 32'hFF000000};
        dir_tab[3]  = '{8'hFE, 1'b0, 3'd2, 32'hFEF00000};
        dir_tab[4]  = '{8'h80, 1'b0, 3'd1, 32'h80000000};
        dir_tab[5]  = '{8'h01, 1'b0, 3'd1, 32'h01000000};
        dir_tab[6]  = '{8'h7F, 1'b1, 3'd0, 32'h0};         // close
        dir_tab[7]  = '{8'h1C, 1'b1, 3'd0, 32'h0};         // checksum low byte stuffed
        dir_tab[8]  = '{8'h00, 1'b1, 3'd0, 32'h0};         // single-byte frames
        dir_tab[9]  = '{8'hFF, 1'b1, 3'd0, 32'h0};
        dir_tab[10] = '{8'hFE, 1'b1, 3'd0, 32'h0};
        dir_tab[11] = '{8'h55, 1'b0, 3'd3, 32'hFEFE5500};
        dir_tab[12] = '{8'hAA, 1'b0, 3'd1, 32'hAA000000};
        dir_tab[13] = '{8'hF0, 1'b1, 3'd0, 32'h0};
        dir_tab[14] = '{8'h00, 1'b0, 3'd3, 32'hFEFE0000};  // left open across a write

        // Register settings per phase: extremes, mark and fill values, reset defaults, random
        hdr_plan[1] = 8'h00;               end_plan[1] = 8'hFF;
        hdr_plan[2] = 8'hFF;               end_plan[2] = 8'h00;
        hdr_plan[3] = sfb_pkg::STUFF_FILL; end_plan[3] = sfb_pkg::STUFF_MARK;
        hdr_plan[4] = 8'h0D;               end_plan[4] = sfb_pkg::STUFF_MARK;
        hdr_plan[5] = 8'($urandom_range(0, 255));
        end_plan[5] = 8'($urandom_range(0, 255));
        hdr_plan[6] = sfb_pkg::HDR_RESET;  end_plan[6] = sfb_pkg::END_RESET;
        hdr_plan[7] = 8'($urandom_range(0, 255));
        end_plan[7] = 8'($urandom_range(0, 255));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_ROWS; k++) begin
            hold_off(1'b0);
            send_payload(dir_tab[k].data, dir_tab[k].last, dir_tab[k].n_typed,
                         dir_tab[k].typed);
        end

        // Random frames, one register setting per phase
        for (ph = 1; ph <= 7; ph++) begin
            hold_off(1'b1);
            repeat (4) @(posedge i_clk);
            calm <= (ph == 3);
            write_reg(sfb_pkg::CFG_HEADER, hdr_plan[ph]);
            write_reg((ph % 2) ? CFG_SPARE_B : CFG_SPARE_A, 8'($urandom_range(0, 255)));
            write_reg(sfb_pkg::CFG_END, end_plan[ph]);
            left = 42;
            while (left > 0) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20)
                                                  : $urandom_range(1, 6);
                for (k = 0; k < len && left > 0; k++) begin
                    lst = (k == len - 1);
                    if (lst && $urandom_range(0, 5) == 0)
                        d = pick_tail(1'($urandom_range(0, 1)));
                    else
                        d = rand_payload();
                    hold_off((ph == 2 && left == 21) ||
                             (!calm && $urandom_range(0, 39) == 0));
                    send_payload(d, lst, 3'd0, 32'h0);
                    left--;
                end
            end
        end

        hold_off(1'b1);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
